FILE: design/assert_macros.svh
// Assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define EHSR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define EHSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ehsr_pkg.sv
// Types, codes and byte-order helpers for the Ethernet header deframer
package ehsr_pkg;

    localparam logic [1:0] HEAD_KEEP = 2'd3;

    typedef enum logic [2:0] {
        PH_DST_HI  = 3'd0,
        PH_DST_LO  = 3'd1,
        PH_SRC_LO  = 3'd2,
        PH_TYPE    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    typedef struct packed {
        logic [31:0] in_data;
        logic [3:0]  in_keep;
        logic        in_last;
        logic        in_valid;
        logic        out_ready;
    } in_word_t;

    typedef struct packed {
        logic [31:0] pay_data;
        logic [3:0]  pay_keep;
        logic        pay_last;
        logic        pay_valid;
        logic        first_word;
        logic        overflow;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] frame_type;
    } res_word_t;

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [3:0] rev4(input logic [3:0] k);
        return {k[0], k[1], k[2], k[3]};
    endfunction

endpackage

FILE: design/ehsr_parse.sv
// Header parser and payload realigner: phase control, held half and header capture
`include "assert_macros.svh"

module ehsr_parse (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  ehsr_pkg::in_word_t  word_in,
    output ehsr_pkg::res_word_t res
);

    ehsr_pkg::phase_t phase_reg, phase_next;
    logic [15:0] held_data_reg, held_data_next;
    logic [1:0]  held_keep_reg, held_keep_next;
    logic        held_valid_reg, held_valid_next;
    logic        held_last_reg, held_last_next;
    logic        first_pend_reg, first_pend_next;
    logic [47:0] dest_mac_reg, dest_mac_next;
    logic [47:0] src_mac_reg, src_mac_next;
    logic [15:0] ftype_reg, ftype_next;
    logic [31:0] out_word_reg, out_word_next;
    logic [3:0]  out_keep_reg, out_keep_next;
    logic        out_last_reg, out_last_next;

    logic [31:0] d;
    logic [3:0]  k;
    logic        vld, rdy, lst;
    logic [15:0] hi_data, lo_data;
    logic [1:0]  hi_keep, lo_keep;
    logic        lo_has, hi_last, lo_valid, full, is_last, emit;
    logic [3:0]  kw;

    assign d        = ehsr_pkg::swap_bytes(word_in.in_data);
    assign k        = ehsr_pkg::rev4(word_in.in_keep);
    assign vld      = word_in.in_valid;
    assign rdy      = word_in.out_ready;
    assign lst      = word_in.in_last;
    assign hi_data  = d[31:16];
    assign lo_data  = d[15:0];
    assign hi_keep  = k[3:2];
    assign lo_keep  = k[1:0];
    assign lo_has   = k[1];
    assign hi_last  = lst & ~lo_has;
    assign lo_valid = vld & lo_has;
    assign full     = held_valid_reg & vld;
    assign is_last  = (held_valid_reg & held_last_reg) | (vld & hi_last);
    assign emit     = (phase_reg == ehsr_pkg::PH_PAYLOAD) & (full | is_last);
    assign kw       = {held_keep_reg, vld ? hi_keep : 2'b00};

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            ehsr_pkg::PH_DST_HI: begin
                if (vld) phase_next = ehsr_pkg::PH_DST_LO;
            end
            ehsr_pkg::PH_DST_LO: begin
                if (vld) phase_next = ehsr_pkg::PH_SRC_LO;
            end
            ehsr_pkg::PH_SRC_LO: begin
                if (vld) phase_next = ehsr_pkg::PH_TYPE;
            end
            ehsr_pkg::PH_TYPE: begin
                if (vld) phase_next = ehsr_pkg::PH_PAYLOAD;
            end
            ehsr_pkg::PH_PAYLOAD: begin
                if (emit && rdy && is_last) phase_next = ehsr_pkg::PH_DST_HI;
            end
            default: begin
                phase_next = ehsr_pkg::PH_DST_HI;
            end
        endcase
    end

    always_comb begin
        held_data_next  = held_data_reg;
        held_keep_next  = held_keep_reg;
        held_valid_next = held_valid_reg;
        held_last_next  = held_last_reg;
        first_pend_next = first_pend_reg;
        dest_mac_next   = dest_mac_reg;
        src_mac_next    = src_mac_reg;
        ftype_next      = ftype_reg;
        out_word_next   = out_word_reg;
        out_keep_next   = out_keep_reg;
        out_last_next   = out_last_reg;
        case (phase_reg)
            ehsr_pkg::PH_DST_HI: begin
                dest_mac_next = {d, dest_mac_reg[15:0]};
            end
            ehsr_pkg::PH_DST_LO: begin
                dest_mac_next = {dest_mac_reg[47:16], hi_data};
                src_mac_next  = {lo_data, src_mac_reg[31:0]};
            end
            ehsr_pkg::PH_SRC_LO: begin
                src_mac_next = {src_mac_reg[47:32], d};
            end
            ehsr_pkg::PH_TYPE: begin
                ftype_next      = hi_data;
                held_data_next  = lo_data;
                held_keep_next  = ehsr_pkg::HEAD_KEEP;
                held_last_next  = 1'b0;
                held_valid_next = 1'b1;
                if (vld) first_pend_next = 1'b1;
            end
            ehsr_pkg::PH_PAYLOAD: begin
                if (emit) begin
                    out_last_next = is_last;
                    out_word_next = ehsr_pkg::swap_bytes({held_data_reg, hi_data});
                    out_keep_next = ehsr_pkg::rev4(kw);
                    if (rdy) begin
                        held_data_next  = lo_data;
                        held_keep_next  = lo_keep;
                        held_valid_next = lo_valid;
                        held_last_next  = lst;
                        first_pend_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.pay_data   = out_word_next;
        res.pay_keep   = out_keep_next;
        res.pay_last   = out_last_next;
        res.pay_valid  = emit;
        res.first_word = emit & first_pend_reg;
        res.overflow   = emit & ~rdy & vld;
        res.dest_mac   = dest_mac_next;
        res.source_mac = src_mac_next;
        res.frame_type = ftype_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= ehsr_pkg::PH_DST_HI;
            held_data_reg  <= '0;
            held_keep_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_last_reg  <= 1'b0;
            first_pend_reg <= 1'b0;
            dest_mac_reg   <= '0;
            src_mac_reg    <= '0;
            ftype_reg      <= '0;
            out_word_reg   <= '0;
            out_keep_reg   <= '0;
            out_last_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            held_data_reg  <= held_data_next;
            held_keep_reg  <= held_keep_next;
            held_valid_reg <= held_valid_next;
            held_last_reg  <= held_last_next;
            first_pend_reg <= first_pend_next;
            dest_mac_reg   <= dest_mac_next;
            src_mac_reg    <= src_mac_next;
            ftype_reg      <= ftype_next;
            out_word_reg   <= out_word_next;
            out_keep_reg   <= out_keep_next;
            out_last_reg   <= out_last_next;
        end
    end

    `EHSR_ASSERT_NOW(a_pay_phase, aclk, aresetn, res.pay_valid, phase_reg == ehsr_pkg::PH_PAYLOAD, "payload offered outside payload phase")
    `EHSR_ASSERT_NOW(a_ovf_stall, aclk, aresetn, res.overflow, res.pay_valid && !rdy, "overflow without stalled payload")
    `EHSR_ASSERT_NEXT(a_type_held, aclk, aresetn, accept && phase_reg == ehsr_pkg::PH_TYPE, held_valid_reg && held_keep_reg == ehsr_pkg::HEAD_KEEP, "held half not loaded from type word")

endmodule

FILE: design/ehsr_skid.sv
// Result register with a skid stage
`include "assert_macros.svh"

module ehsr_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ehsr_pkg::res_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output ehsr_pkg::res_word_t out_word
);

    ehsr_pkg::res_word_t main_reg, skid_reg;
    logic main_valid_reg, skid_valid_reg;
    logic main_load;

    assign in_ready  = ~skid_valid_reg;
    assign main_load = ~main_valid_reg | out_ready;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_load) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_load) begin
            main_reg <= skid_valid_reg ? skid_reg : in_word;
        end else if (in_valid && in_ready) begin
            skid_reg <= in_word;
        end
    end

    `EHSR_ASSERT_NOW(a_skid_order, aclk, aresetn, skid_valid_reg, main_valid_reg, "skid word held without a main word")
    `EHSR_ASSERT_NEXT(a_skid_drain, aclk, aresetn, skid_valid_reg && out_ready, !skid_valid_reg && main_valid_reg && main_reg == $past(skid_reg), "skid word not moved to main")

endmodule

FILE: design/eth_header_strip_realign_32_core.sv
// Ethernet receive deframer, 32-bit: header capture and payload realignment
//
//  Channel  Direction  Handshake          Word
//  s_       in         s_valid / s_ready  stream word, keep, last, valid, downstream ready
//  m_       out        m_valid / m_ready  payload word, flags, captured header
//
//  One result per accepted word; it is registered in the main result entry, or in the skid entry while m_ is stalled.
//  Sustained rate one word per clock while m_ready stays high; the parser state updates on the accept edge.
//  A two-entry result stage (register plus skid) decouples s_ready from m_ready.
//  s_ready drops only while the skid entry is occupied.
//  aresetn is synchronous, active low; it clears the parser and the valid flags of both result entries.
module eth_header_strip_realign_32_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_in_data,
    input  logic [3:0]  s_in_keep,
    input  logic        s_in_last,
    input  logic        s_in_valid,
    input  logic        s_out_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pay_data,
    output logic [3:0]  m_pay_keep,
    output logic        m_pay_last,
    output logic        m_pay_valid,
    output logic        m_first_word,
    output logic        m_overflow,
    output logic [47:0] m_dest_mac,
    output logic [47:0] m_source_mac,
    output logic [15:0] m_frame_type
);

    ehsr_pkg::in_word_t  word_in;
    ehsr_pkg::res_word_t res, res_out;
    logic accept;

    assign accept = s_valid & s_ready;

    assign word_in.in_data   = s_in_data;
    assign word_in.in_keep   = s_in_keep;
    assign word_in.in_last   = s_in_last;
    assign word_in.in_valid  = s_in_valid;
    assign word_in.out_ready = s_out_ready;

    ehsr_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .word_in (word_in),
        .res     (res)
    );

    ehsr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (res_out)
    );

    assign m_pay_data   = res_out.pay_data;
    assign m_pay_keep   = res_out.pay_keep;
    assign m_pay_last   = res_out.pay_last;
    assign m_pay_valid  = res_out.pay_valid;
    assign m_first_word = res_out.first_word;
    assign m_overflow   = res_out.overflow;
    assign m_dest_mac   = res_out.dest_mac;
    assign m_source_mac = res_out.source_mac;
    assign m_frame_type = res_out.frame_type;

endmodule
